>>> rtl/tcfx_pkg.sv
// Package: shared types and constants for the tracker channel effect engine.
`timescale 1ns / 1ps
package tcfx_pkg;
    localparam int NUM_VOICES = 7;
    localparam int VW = 3;

    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_ARP   = 3'd1;
    localparam logic [2:0] K_PITCH = 3'd2;
    localparam logic [2:0] K_FADE  = 3'd3;
    localparam logic [2:0] K_TREM  = 3'd4;

    localparam logic [7:0] FX_INST  = 8'd1;
    localparam logic [7:0] FX_ARP   = 8'd2;
    localparam logic [7:0] FX_UP    = 8'd3;
    localparam logic [7:0] FX_DOWN  = 8'd4;
    localparam logic [7:0] FX_FIN   = 8'd5;
    localparam logic [7:0] FX_FOUT  = 8'd6;
    localparam logic [7:0] FX_TREM  = 8'd7;
    localparam logic [7:0] KEEP_VOL = 8'hFF;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    localparam logic [2:0] ADDR_NOISE = 3'd0;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  voice;
        logic [15:0] note_freq;
        logic [7:0]  row_volume;
        logic [7:0]  effect_id;
        logic [7:0]  effect_x;
        logic [7:0]  effect_y;
        logic [15:0] alt_freq_x;
        logic [15:0] alt_freq_y;
        logic [7:0]  slide_speed;
    } t_in;

    typedef struct packed {
        logic [2:0]  out_voice;
        logic        freq_write;
        logic [15:0] frequency;
        logic        vol_write;
        logic [7:0]  volume;
        logic        wave_write;
        logic [7:0]  instrument;
        logic [1:0]  noise_mode;
        logic        fx_active;
        logic        last;
    } t_out;

    // one memory word per voice
    typedef struct packed {
        logic [15:0] base_pitch;
        logic [2:0]  effect_kind;
        logic [15:0] arp_note_two;
        logic [15:0] arp_note_three;
        logic [1:0]  arp_length;
        logic [1:0]  arp_position;
        logic [15:0] slide_target;
        logic [15:0] slide_now;
        logic [7:0]  set_volume;
        logic [7:0]  fade_goal;
        logic [7:0]  fade_now;
        logic [7:0]  hold_ticks;
        logic [7:0]  hold_left;
        logic        trem_muted;
    } t_vstate;

    localparam t_vstate VSTATE_RESET = '{
        base_pitch: 16'd0, effect_kind: K_NONE, arp_note_two: 16'd0,
        arp_note_three: 16'd0, arp_length: 2'd3, arp_position: 2'd0,
        slide_target: 16'd0, slide_now: 16'd0, set_volume: 8'd0,
        fade_goal: 8'd0, fade_now: 8'd0, hold_ticks: 8'd0, hold_left: 8'd0,
        trem_muted: 1'b0};

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_OUT} t_state;
endpackage

>>> rtl/tracker_channel_fx_engine.sv
// Top level: handshake, APB register, sequencer around the voice state memory.
`timescale 1ns / 1ps
// A row event's result is registered after acceptance by a memory read, then an
// update with write-back and result register load, and the next transaction is
// taken after a settle step; a tick walks the 7 voices through the same
// read-modify-write; every update waits while an earlier result is not yet taken,
// and the sequencer then returns to idle. One transaction is in flight at a time; the
// sequencer's read, update and settle steps set the rate. Row events for a voice
// number of 7 give no result.
module tracker_channel_fx_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  tcfx_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output tcfx_pkg::t_out   o_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tcfx_pkg::*;
    t_state r_state, n_state;
    t_in    r_in;
    logic [2:0] r_voice, n_voice;
    logic [7:0] r_noise;
    t_out   r_out;
    logic   r_ovalid;
    t_vstate rd, wr;
    t_out   res;
    logic   we, load_out;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NOISE) ? {24'd0, r_noise} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_noise <= 8'hFF;
        else if (psel && penable && pwrite && paddr == ADDR_NOISE) r_noise <= pwdata[7:0];
    end

    assign o_stall = (r_state != S_IDLE);

    tcfx_mem u_mem (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(we), .i_waddr(r_voice),
                    .i_wdata(wr), .i_raddr(r_voice), .o_rdata(rd));
    tcfx_calc u_calc (.i_in(r_in), .i_voice(r_voice), .i_noise_inst(r_noise),
                      .i_st(rd), .o_st(wr), .o_res(res));

    always_comb begin
        n_state = r_state;
        n_voice = r_voice;
        we = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: if (i_valid) begin
                n_state = S_READ;
                n_voice = (i_data.opcode == OP_TICK) ? 3'd0 : i_data.voice;
                if (i_data.opcode == OP_ROW && i_data.voice >= 3'(NUM_VOICES))
                    n_state = S_IDLE;
            end
            S_READ: n_state = S_CALC;
            S_CALC: if (!r_ovalid || !i_stall) begin
                we = 1'b1;
                load_out = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (r_in.opcode == OP_TICK && r_voice != 3'(NUM_VOICES - 1)) begin
                    n_voice = r_voice + 3'd1;
                    n_state = S_READ;
                end else n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_voice <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
            if (load_out) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) r_in <= i_data;
        if (load_out) r_out <= res;
    end

    assign o_valid = r_ovalid;
    assign o_data = r_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accepted while busy");
    a_write_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> o_valid) else $error("write-back without result");
    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_voice < 3'(NUM_VOICES))) else $error("bad voice");
endmodule

>>> rtl/tcfx_mem.sv
// Voice state memory: one write port, one registered read port, valid bits.
`timescale 1ns / 1ps
module tcfx_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [2:0]         i_waddr,
    input  tcfx_pkg::t_vstate  i_wdata,
    input  logic [2:0]         i_raddr,
    output tcfx_pkg::t_vstate  o_rdata
);
    import tcfx_pkg::*;
    t_vstate r_mem [NUM_VOICES];
    logic [NUM_VOICES-1:0] r_valid;
    t_vstate r_rd;
    logic r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rd <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) r_valid[i_waddr] <= 1'b1;
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rd : VSTATE_RESET;
endmodule

>>> rtl/tcfx_calc.sv
// Per-voice update: row event and effect tick logic on one state word.
`timescale 1ns / 1ps
module tcfx_calc (
    input  tcfx_pkg::t_in      i_in,
    input  logic [2:0]         i_voice,
    input  logic [7:0]         i_noise_inst,
    input  tcfx_pkg::t_vstate  i_st,
    output tcfx_pkg::t_vstate  o_st,
    output tcfx_pkg::t_out     o_res
);
    import tcfx_pkg::*;
    logic [16:0] sum, diff;
    logic [9:0]  step;
    logic        had_freq, had_vol, fresh_note;
    logic [1:0]  pos1;

    always_comb begin
        o_st = i_st;
        o_res = '0;
        o_res.out_voice = i_voice;
        step = {i_in.slide_speed, 2'b00};
        sum = {1'b0, i_st.slide_now} + {7'd0, step};
        diff = (i_st.slide_now > {6'd0, step}) ?
               {1'b0, i_st.slide_now} - {7'd0, step} : 17'd0;
        pos1 = i_st.arp_position + 2'd1;
        had_freq = (i_st.effect_kind == K_ARP) || (i_st.effect_kind == K_PITCH);
        had_vol = (i_st.effect_kind == K_FADE) || (i_st.effect_kind == K_TREM);
        fresh_note = i_in.note_freq != 16'd0;
        if (i_in.opcode == OP_TICK) begin
            o_res.last = (i_voice == 3'(NUM_VOICES - 1));
            case (i_st.effect_kind)
                K_ARP: begin
                    o_res.freq_write = 1'b1;
                    o_res.frequency = (i_st.arp_position == 2'd0) ? i_st.base_pitch :
                                      (i_st.arp_position == 2'd1) ? i_st.arp_note_two :
                                      i_st.arp_note_three;
                    o_st.arp_position = ({1'b0, i_st.arp_position} + 3'd1 >=
                                         {1'b0, i_st.arp_length}) ? 2'd0 : pos1;
                end
                K_PITCH: begin
                    if (i_st.slide_now < i_st.slide_target) begin
                        if (sum >= {1'b0, i_st.slide_target}) begin
                            o_st.effect_kind = K_NONE;
                            o_st.slide_now = i_st.slide_target;
                        end else o_st.slide_now = sum[15:0];
                    end else if (i_st.slide_now > i_st.slide_target) begin
                        if (diff <= {1'b0, i_st.slide_target}) begin
                            o_st.effect_kind = K_NONE;
                            o_st.slide_now = i_st.slide_target;
                        end else o_st.slide_now = diff[15:0];
                    end else begin
                        o_st.effect_kind = K_NONE;
                    end
                    o_res.freq_write = 1'b1;
                    o_res.frequency = o_st.slide_now;
                end
                K_FADE: begin
                    if (i_st.hold_left == 8'd0) begin
                        if (i_st.fade_now < i_st.fade_goal)
                            o_st.fade_now = i_st.fade_now + 8'd1;
                        else if (i_st.fade_now > i_st.fade_goal)
                            o_st.fade_now = i_st.fade_now - 8'd1;
                        o_res.vol_write = 1'b1;
                        o_res.volume = o_st.fade_now;
                        if (o_st.fade_now == i_st.fade_goal) o_st.effect_kind = K_NONE;
                        o_st.hold_left = i_st.hold_ticks;
                    end else o_st.hold_left = i_st.hold_left - 8'd1;
                end
                K_TREM: begin
                    if (i_st.hold_left == 8'd0) begin
                        o_st.trem_muted = ~i_st.trem_muted;
                        o_res.vol_write = 1'b1;
                        o_res.volume = o_st.trem_muted ? 8'd0 : i_st.set_volume;
                        o_st.hold_left = i_st.hold_ticks;
                    end else o_st.hold_left = i_st.hold_left - 8'd1;
                end
                default: ;
            endcase
        end else begin
            o_res.last = 1'b1;
            if (fresh_note) o_st.base_pitch = i_in.note_freq;
            if (i_in.row_volume != KEEP_VOL) begin
                o_st.set_volume = i_in.row_volume;
                o_res.vol_write = 1'b1;
                o_res.volume = i_in.row_volume;
            end
            case (i_in.effect_id)
                FX_ARP: begin
                    o_st.effect_kind = K_ARP;
                    o_st.arp_note_two = i_in.alt_freq_x;
                    o_st.arp_note_three = i_in.alt_freq_y;
                    o_st.arp_length = (i_in.effect_y == 8'hFF) ? 2'd2 : 2'd3;
                    o_st.arp_position = 2'd0;
                    o_res.fx_active = 1'b1;
                end
                FX_UP, FX_DOWN: begin
                    o_st.effect_kind = K_PITCH;
                    o_st.slide_target = i_in.alt_freq_x;
                    o_st.slide_now = o_st.base_pitch;
                    o_res.freq_write = 1'b1;
                    o_res.frequency = o_st.base_pitch;
                    o_res.fx_active = 1'b1;
                end
                FX_FIN, FX_FOUT: begin
                    o_st.effect_kind = K_FADE;
                    if (i_in.effect_id == FX_FIN) begin
                        o_st.fade_goal = o_st.set_volume;
                        o_st.fade_now = 8'd0;
                    end else begin
                        o_st.fade_goal = 8'd0;
                        o_st.fade_now = o_st.set_volume;
                    end
                    o_res.vol_write = 1'b1;
                    o_res.volume = o_st.fade_now;
                    o_st.hold_ticks = i_in.effect_x;
                    o_st.hold_left = i_in.effect_x;
                    if (fresh_note || had_freq) begin
                        o_res.freq_write = 1'b1;
                        o_res.frequency = o_st.base_pitch;
                    end
                    o_res.fx_active = 1'b1;
                end
                FX_TREM: begin
                    o_st.effect_kind = K_TREM;
                    o_st.hold_ticks = i_in.effect_x;
                    o_st.hold_left = i_in.effect_x;
                    o_st.trem_muted = 1'b0;
                    if (fresh_note || had_freq) begin
                        o_res.freq_write = 1'b1;
                        o_res.frequency = o_st.base_pitch;
                    end
                    o_res.fx_active = 1'b1;
                end
                default: begin
                    if (i_in.effect_id == FX_INST) begin
                        o_res.wave_write = 1'b1;
                        if (i_in.effect_x == i_noise_inst) begin
                            o_res.noise_mode = (i_in.effect_y == 8'd0) ? 2'd1 : 2'd2;
                        end else begin
                            o_res.instrument = i_in.effect_x;
                        end
                    end
                    o_st.effect_kind = K_NONE;
                    if (fresh_note || had_freq) begin
                        o_res.freq_write = 1'b1;
                        o_res.frequency = o_st.base_pitch;
                    end
                    if (had_vol) begin
                        o_res.vol_write = 1'b1;
                        o_res.volume = o_st.set_volume;
                    end
                end
            endcase
        end
    end
endmodule

>>> dv/tracker_channel_fx_engine_tb.sv
// Testbench: random and directed row events and ticks checked against a voice effect predictor.
`timescale 1ns / 1ps
module tracker_channel_fx_engine_tb;
    import tcfx_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tracker_channel_fx_engine u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [7:0]  noise_inst;
    t_vstate     voices [NUM_VOICES];

    t_in  pending_items [$];
    t_out expected_results [$];
    int   mismatches;
    bit   in_gap_enable;
    bit   out_stall_enable;
    int   in_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // advances one voice on an effect tick
    function automatic t_out tick_one(int v, logic [7:0] speed);
        t_out o;
        logic [16:0] cur, tgt, sum, nxt;
        logic [9:0]  stp;
        logic [7:0]  fcur;
        o = '0;
        o.out_voice = v[2:0];
        stp = {speed, 2'b00};
        case (voices[v].effect_kind)
            K_ARP: begin
                o.freq_write = 1'b1;
                o.frequency = (voices[v].arp_position == 0) ? voices[v].base_pitch :
                    (voices[v].arp_position == 1) ? voices[v].arp_note_two :
                    voices[v].arp_note_three;
                if ({1'b0, voices[v].arp_position} + 3'd1 >= {1'b0, voices[v].arp_length})
                    voices[v].arp_position = 2'd0;
                else
                    voices[v].arp_position = voices[v].arp_position + 2'd1;
            end
            K_PITCH: begin
                cur = voices[v].slide_now;
                tgt = voices[v].slide_target;
                if (cur < tgt) begin
                    sum = cur + stp;
                    if (sum >= tgt) begin
                        voices[v].effect_kind = K_NONE;
                        nxt = tgt;
                    end else nxt = sum;
                end else if (cur > tgt) begin
                    sum = (cur > stp) ? cur - stp : 17'd0;
                    if (sum <= tgt) begin
                        voices[v].effect_kind = K_NONE;
                        nxt = tgt;
                    end else nxt = sum;
                end else begin
                    voices[v].effect_kind = K_NONE;
                    nxt = tgt;
                end
                voices[v].slide_now = nxt[15:0];
                o.freq_write = 1'b1;
                o.frequency = nxt[15:0];
            end
            K_FADE: begin
                if (voices[v].hold_left == 0) begin
                    fcur = voices[v].fade_now;
                    if (fcur < voices[v].fade_goal) fcur++;
                    else if (fcur > voices[v].fade_goal) fcur--;
                    voices[v].fade_now = fcur;
                    o.vol_write = 1'b1;
                    o.volume = fcur;
                    if (fcur == voices[v].fade_goal) voices[v].effect_kind = K_NONE;
                    voices[v].hold_left = voices[v].hold_ticks;
                end else voices[v].hold_left--;
            end
            K_TREM: begin
                if (voices[v].hold_left == 0) begin
                    voices[v].trem_muted = ~voices[v].trem_muted;
                    o.vol_write = 1'b1;
                    o.volume = voices[v].trem_muted ? 8'd0 : voices[v].set_volume;
                    voices[v].hold_left = voices[v].hold_ticks;
                end else voices[v].hold_left--;
            end
            default: ;
        endcase
        o.last = (v == NUM_VOICES - 1);
        return o;
    endfunction

    // computes the results of one accepted transaction
    function automatic void predict_effects(t_in it);
        t_out o;
        int v;
        logic [2:0] prev;
        bit fresh_note, had_freq, had_vol;
        if (it.opcode == OP_TICK) begin
            for (int c = 0; c < NUM_VOICES; c++)
                expected_results.push_back(tick_one(c, it.slide_speed));
            return;
        end
        v = int'(it.voice);
        if (v >= NUM_VOICES) return;
        o = '0;
        o.out_voice = it.voice;
        o.last = 1'b1;
        prev = voices[v].effect_kind;
        had_freq = (prev == K_ARP) || (prev == K_PITCH);
        had_vol = (prev == K_FADE) || (prev == K_TREM);
        fresh_note = it.note_freq != 0;
        if (fresh_note) voices[v].base_pitch = it.note_freq;
        if (it.row_volume != KEEP_VOL) begin
            voices[v].set_volume = it.row_volume;
            o.vol_write = 1'b1;
            o.volume = it.row_volume;
        end
        if (it.effect_id == FX_ARP) begin
            voices[v].effect_kind = K_ARP;
            voices[v].arp_note_two = it.alt_freq_x;
            voices[v].arp_note_three = it.alt_freq_y;
            voices[v].arp_length = (it.effect_y == 8'hFF) ? 2'd2 : 2'd3;
            voices[v].arp_position = 2'd0;
            o.fx_active = 1'b1;
        end else if (it.effect_id == FX_UP || it.effect_id == FX_DOWN) begin
            voices[v].effect_kind = K_PITCH;
            voices[v].slide_target = it.alt_freq_x;
            voices[v].slide_now = voices[v].base_pitch;
            o.freq_write = 1'b1;
            o.frequency = voices[v].base_pitch;
            o.fx_active = 1'b1;
        end else if (it.effect_id == FX_FIN || it.effect_id == FX_FOUT ||
                     it.effect_id == FX_TREM) begin
            if (it.effect_id == FX_TREM) begin
                voices[v].effect_kind = K_TREM;
                voices[v].trem_muted = 1'b0;
            end else begin
                voices[v].effect_kind = K_FADE;
                if (it.effect_id == FX_FIN) begin
                    voices[v].fade_goal = voices[v].set_volume;
                    voices[v].fade_now = 8'd0;
                end else begin
                    voices[v].fade_goal = 8'd0;
                    voices[v].fade_now = voices[v].set_volume;
                end
                // fade start volume wins over the row volume
                o.vol_write = 1'b1;
                o.volume = voices[v].fade_now;
            end
            voices[v].hold_ticks = it.effect_x;
            voices[v].hold_left = it.effect_x;
            if (fresh_note || had_freq) begin
                o.freq_write = 1'b1;
                o.frequency = voices[v].base_pitch;
            end
            o.fx_active = 1'b1;
        end else begin
            if (it.effect_id == FX_INST) begin
                o.wave_write = 1'b1;
                if (it.effect_x == noise_inst) begin
                    o.instrument = 8'd0;
                    o.noise_mode = (it.effect_y == 0) ? 2'd1 : 2'd2;
                end else begin
                    o.instrument = it.effect_x;
                    o.noise_mode = 2'd0;
                end
            end
            voices[v].effect_kind = K_NONE;
            if (fresh_note || had_freq) begin
                o.freq_write = 1'b1;
                o.frequency = voices[v].base_pitch;
            end
            if (had_vol) begin
                o.vol_write = 1'b1;
                o.volume = voices[v].set_volume;
            end
        end
        expected_results.push_back(o);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            in_gap <= 0;
        end else if (i_valid && !o_stall) begin
            predict_effects(i_data);
            if (pending_items.size() > 0 && in_gap_enable && pick_gap() != 0) begin
                i_valid <= 1'b0;
                in_gap <= pick_gap();
            end else if (pending_items.size() > 0) begin
                i_data <= pending_items.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (in_gap > 0) in_gap <= in_gap - 1;
            else if (pending_items.size() > 0) begin
                i_data <= pending_items.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", o_data);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_data !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, o_data);
                    end
                end
            end
            i_stall <= out_stall_enable ? (pick_gap() != 0) : 1'b0;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        noise_inst = data[7:0];
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_in random_item();
        t_in it;
        int r;
        it.opcode = OP_ROW;
        it.voice = $urandom_range(0, 7);
        it.note_freq = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        it.row_volume = ($urandom_range(0, 2) == 0) ? KEEP_VOL : 8'($urandom);
        r = $urandom_range(0, 9);
        it.effect_id = (r <= 7) ? 8'(r) : 8'($urandom);
        it.effect_x = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        if (it.effect_id == FX_INST && $urandom_range(0, 2) == 0) it.effect_x = noise_inst;
        it.effect_y = ($urandom_range(0, 2) == 0) ? 8'hFF :
                      ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
        it.alt_freq_x = 16'($urandom);
        it.alt_freq_y = 16'($urandom);
        it.slide_speed = 8'($urandom);
        return it;
    endfunction

    function automatic t_in tick_item(logic [7:0] speed);
        t_in it;
        it = '0;
        it.opcode = OP_TICK;
        it.voice = 3'($urandom);
        it.slide_speed = speed;
        return it;
    endfunction

    initial begin
        t_in it;
        logic [7:0] noise_set [3];
        mismatches = 0;
        in_gap_enable = 1'b0;
        out_stall_enable = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        noise_inst = 8'hFF;
        for (int v = 0; v < NUM_VOICES; v++) voices[v] = VSTATE_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every effect, extremes, noise select, ignored voice
        for (int e = 0; e <= 8; e++) begin
            it = '0;
            it.opcode = OP_ROW;
            it.voice = 3'(e % NUM_VOICES);
            it.note_freq = (e % 2) ? 16'hFFFF : 16'd1;
            it.row_volume = (e == 0) ? KEEP_VOL : 8'(255 - e);
            it.effect_id = (e == 8) ? 8'hFF : 8'(e);
            it.effect_x = (e == 1) ? 8'hFF : 8'd0;
            it.effect_y = (e == 2) ? 8'hFF : 8'd0;
            it.alt_freq_x = (e == 4) ? 16'd0 : 16'hFFFF;
            it.alt_freq_y = 16'h0123;
            pending_items.push_back(it);
        end
        it.voice = 3'd7;
        pending_items.push_back(it);
        pending_items.push_back(tick_item(8'hFF));
        pending_items.push_back(tick_item(8'd0));
        pending_items.push_back(tick_item(8'd1));
        it = '0;
        it.opcode = OP_ROW;
        it.voice = 3'd1;
        it.effect_id = FX_INST;
        it.effect_x = 8'hFF;
        it.effect_y = 8'd5;
        pending_items.push_back(it);
        pending_items.push_back(tick_item(8'd3));
        drain();

        noise_set[0] = 8'd0;
        noise_set[1] = 8'($urandom_range(1, 254));
        noise_set[2] = 8'hFF;
        for (int ph = 0; ph < 3; ph++) begin
            apb_write(ADDR_NOISE, {24'($urandom), noise_set[ph]});
            in_gap_enable = (ph != 1);
            out_stall_enable = (ph != 0);
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(0, 3) == 0)
                    pending_items.push_back(tick_item(
                        ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8))));
                else
                    pending_items.push_back(random_item());
                // sender holds off until the block has caught up
                if (n == 75) begin
                    while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
                        @(posedge i_clk);
                end
            end
            drain();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/tcfx_pkg.sv
rtl/tcfx_mem.sv
rtl/tcfx_calc.sv
rtl/tracker_channel_fx_engine.sv
dv/tracker_channel_fx_engine_tb.sv
